// ===== rtl/scea_pkg.sv =====
// Shared types, constants and the logarithm table of the cross-entropy accuracy block.
package scea_pkg;

  // Class and table sizing.
  localparam int MAX_CLASSES     = 1024;
  localparam int LOG_TABLE_DEPTH = 256;
  localparam int CLS_W           = $clog2(MAX_CLASSES);
  localparam int LOG_W           = $clog2(LOG_TABLE_DEPTH);

  // Field widths.
  localparam int PROB_W  = 17;
  localparam int GRAD_W  = 18;
  localparam int NCLS_W  = 11;
  localparam int LOSS_W  = 32;
  localparam int CNT_W   = 16;
  localparam int TERM_W  = 21;
  localparam int LNT_W   = 16;
  localparam int SHIFT_W = 5;

  // Fixed-point constants.
  localparam logic [PROB_W-1:0] ONE_Q16    = PROB_W'(65536);
  localparam logic [LNT_W-1:0]  LN2_Q16    = LNT_W'(45426);
  localparam logic [31:0]       LN2_Q32    = 32'd2977044472;
  localparam logic [TERM_W-1:0] LOSS_CLAMP = TERM_W'(1207218);
  localparam logic [NCLS_W-1:0] NCLS_RESET = NCLS_W'(10);
  localparam logic [NCLS_W-1:0] NCLS_MAX   = NCLS_W'(MAX_CLASSES);

  typedef logic [PROB_W-1:0]        prob_t;
  typedef logic [CLS_W-1:0]         cls_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [NCLS_W-1:0]        ncls_t;
  typedef logic [LOSS_W-1:0]        loss_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [TERM_W-1:0]        term_t;

  // Payload handed from the log stage to the accumulate stage.
  typedef struct packed {
    prob_t prob;
    cls_t  label;
    logic  batch_start;
    term_t term;
  } scea_stage_t;

  typedef logic [LNT_W-1:0] ln_tab_t [LOG_TABLE_DEPTH];

  // ln(1 + i/LOG_TABLE_DEPTH) in unsigned Q0.16 by repeated squaring, evaluated at elaboration.
  function automatic logic [LNT_W-1:0] ln_mantissa(int unsigned i);
    logic [63:0] y;
    logic [63:0] l;
    y = (64'd1 << 30) + ((64'(i) << 30) >> LOG_W);
    l = 64'd0;
    for (int b = 0; b < 24; b++) begin
      y = (y * y) >> 30;
      l = l << 1;
      if (y >= (64'd2 << 30)) begin
        y    = y >> 1;
        l[0] = 1'b1;
      end
    end
    return LNT_W'((l * 64'(LN2_Q32) + (64'd1 << 39)) >> 40);
  endfunction

  function automatic ln_tab_t build_ln_tab();
    ln_tab_t t;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      t[i] = ln_mantissa(i);
    end
    return t;
  endfunction

  localparam ln_tab_t LN_TAB = build_ln_tab();

endpackage

// ===== rtl/scea_if.sv =====
// Valid/ready channel interfaces for the probability input and the result output.
interface scea_in_if;
  import scea_pkg::*;

  logic  valid;
  logic  ready;
  prob_t prob;
  cls_t  label;
  logic  batch_start;

  modport source (output valid, prob, label, batch_start, input ready);
  modport sink   (input valid, prob, label, batch_start, output ready);
endinterface

interface scea_out_if;
  import scea_pkg::*;

  logic  valid;
  logic  ready;
  grad_t grad;
  logic  sample_done;
  cls_t  predicted_class;
  logic  sample_correct;
  loss_t loss_total;
  cnt_t  correct_total;

  modport source (output valid, grad, sample_done, predicted_class, sample_correct,
                  loss_total, correct_total, input ready);
  modport sink   (input valid, grad, sample_done, predicted_class, sample_correct,
                  loss_total, correct_total, output ready);
endinterface

// ===== rtl/scea_lnterm.sv =====
// Input stage: saturates the probability and registers its -ln loss term.
module scea_lnterm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  scea_pkg::prob_t       in_prob,
  input  scea_pkg::cls_t        in_label,
  input  logic                  in_batch_start,
  input  logic                  advance,
  output logic                  s1_valid,
  output scea_pkg::scea_stage_t s1_data
);
  import scea_pkg::*;

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  scea_stage_t          s1_data_r;
  scea_stage_t          s1_data_nxt;
  prob_t                p_sat;
  logic [SHIFT_W-1:0]   lead;
  prob_t                mant;
  logic [PROB_W+LOG_W-1:0] idx_wide;
  logic [LOG_W-1:0]     idx;
  logic [LNT_W-1:0]     ln_val;
  term_t                base;
  term_t                term;

  // The stage takes a transaction whenever it is empty or moving on.
  assign in_ready = !s1_valid_r || advance;

  // Probabilities above one count as one.
  assign p_sat = (in_prob > ONE_Q16) ? ONE_Q16 : in_prob;

  // Leading-one position of the probability.
  always_comb begin
    lead = '0;
    for (int i = 0; i < PROB_W; i++) begin
      if (p_sat[i]) begin
        lead = SHIFT_W'(i);
      end
    end
  end

  // Mantissa bits below the leading one, scaled to a table index.
  assign mant     = p_sat - (PROB_W'(1) << lead);
  assign idx_wide = {mant, {LOG_W{1'b0}}} >> lead;
  assign idx      = idx_wide[LOG_W-1:0];
  assign ln_val   = LN_TAB[idx];

  // term = (16 - k) * ln2 - ln(1 + f), clamped; zero probability takes the clamp.
  always_comb begin
    base = TERM_W'(SHIFT_W'(16) - lead) * TERM_W'(LN2_Q16);
    if (p_sat == '0) begin
      term = LOSS_CLAMP;
    end else if (base >= TERM_W'(ln_val)) begin
      term = base - TERM_W'(ln_val);
    end else begin
      term = '0;
    end
    if (term > LOSS_CLAMP) begin
      term = LOSS_CLAMP;
    end
  end

  // Stage register.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_data_nxt  = s1_data_r;
    if (in_ready) begin
      s1_valid_nxt            = in_valid;
      s1_data_nxt.prob        = p_sat;
      s1_data_nxt.label       = in_label;
      s1_data_nxt.batch_start = in_batch_start;
      s1_data_nxt.term        = term;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r <= s1_data_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

// ===== rtl/scea_accum.sv =====
// Accumulate stage: gradient, running argmax, loss and accuracy totals, result register.
module scea_accum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scea_pkg::ncls_t       num_classes,
  input  logic                  s1_valid,
  input  scea_pkg::scea_stage_t s1_data,
  output logic                  advance,
  output logic                  out_valid,
  input  logic                  out_ready,
  output scea_pkg::grad_t       out_grad,
  output logic                  out_sample_done,
  output scea_pkg::cls_t        out_predicted_class,
  output logic                  out_sample_correct,
  output scea_pkg::loss_t       out_loss_total,
  output scea_pkg::cnt_t        out_correct_total
);
  import scea_pkg::*;

  // Sample and batch state.
  cls_t  class_index_r, class_index_nxt;
  cls_t  held_label_r,  held_label_nxt;
  prob_t best_prob_r,   best_prob_nxt;
  cls_t  best_index_r,  best_index_nxt;
  loss_t loss_sum_r,    loss_sum_nxt;
  cnt_t  correct_cnt_r, correct_cnt_nxt;

  // Result register.
  logic  out_valid_r,   out_valid_nxt;
  grad_t grad_r,        grad_nxt;
  logic  done_r,        done_nxt;
  cls_t  pred_r,        pred_nxt;
  logic  correct_r,     correct_nxt;

  ncls_t             n_eff;
  logic              first;
  logic              is_label;
  logic              last;
  logic              take;
  loss_t             loss_base;
  cnt_t              cnt_base;
  logic [LOSS_W:0]   loss_add;
  cls_t              lbl;
  prob_t             bp;
  cls_t              bi;

  // The result register frees up when it is empty or being read.
  assign advance = !out_valid_r || out_ready;
  assign take    = advance && s1_valid;

  // Class count limited to the supported range.
  always_comb begin
    n_eff = num_classes;
    if (num_classes == '0) begin
      n_eff = NCLS_W'(1);
    end else if (num_classes > NCLS_MAX) begin
      n_eff = NCLS_MAX;
    end
  end

  // Per-element update of the sample state and the totals.
  always_comb begin
    first     = (class_index_r == '0);
    lbl       = first ? s1_data.label : held_label_r;
    bp        = first ? '0 : best_prob_r;
    bi        = first ? '0 : best_index_r;
    loss_base = s1_data.batch_start ? '0 : loss_sum_r;
    cnt_base  = s1_data.batch_start ? '0 : correct_cnt_r;
    is_label  = (class_index_r == lbl);

    loss_add = {1'b0, loss_base} + (LOSS_W+1)'(s1_data.term);
    if (is_label) begin
      loss_sum_nxt = loss_add[LOSS_W] ? '1 : loss_add[LOSS_W-1:0];
    end else begin
      loss_sum_nxt = loss_base;
    end

    if (s1_data.prob > bp) begin
      bp = s1_data.prob;
      bi = class_index_r;
    end

    last        = ((NCLS_W'(class_index_r) + NCLS_W'(1)) >= n_eff);
    correct_nxt = last && (bi == lbl);
    correct_cnt_nxt = (correct_nxt && cnt_base != '1) ? cnt_base + CNT_W'(1) : cnt_base;

    grad_nxt = $signed({1'b0, is_label, {(GRAD_W-2){1'b0}}})
             - $signed({1'b0, s1_data.prob});
    done_nxt = last;
    pred_nxt = bi;

    class_index_nxt = last ? '0 : class_index_r + CLS_W'(1);
    held_label_nxt  = lbl;
    best_prob_nxt   = bp;
    best_index_nxt  = bi;
    out_valid_nxt   = advance ? s1_valid : out_valid_r;
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      class_index_r <= '0;
      held_label_r  <= '0;
      best_prob_r   <= '0;
      best_index_r  <= '0;
      loss_sum_r    <= '0;
      correct_cnt_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        class_index_r <= class_index_nxt;
        held_label_r  <= held_label_nxt;
        best_prob_r   <= best_prob_nxt;
        best_index_r  <= best_index_nxt;
        loss_sum_r    <= loss_sum_nxt;
        correct_cnt_r <= correct_cnt_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      grad_r    <= grad_nxt;
      done_r    <= done_nxt;
      pred_r    <= pred_nxt;
      correct_r <= correct_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_grad            = grad_r;
  assign out_sample_done     = done_r;
  assign out_predicted_class = pred_r;
  assign out_sample_correct  = correct_r;
  assign out_loss_total      = loss_sum_r;
  assign out_correct_total   = correct_cnt_r;

  // A sample can only be marked correct on its last element.
  a_correct_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!correct_r || done_r))
    else $error("sample marked correct before its last element");

  // The loss total never falls within a batch.
  a_loss_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !s1_data.batch_start) |=> (loss_sum_r >= $past(loss_sum_r)))
    else $error("loss total decreased without a batch start");

  // A finished sample restarts the class position.
  a_index_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last) |=> (class_index_r == '0))
    else $error("class position did not restart after the last element");

  // The correct count steps by at most one per element.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !s1_data.batch_start) |=>
      (correct_cnt_r == $past(correct_cnt_r) ||
       correct_cnt_r == $past(correct_cnt_r) + CNT_W'(1)))
    else $error("correct count jumped by more than one");

endmodule

// ===== rtl/softmax_cross_entropy_accuracy_core.sv =====
// Top level of the streaming softmax cross-entropy loss and argmax accuracy block.
// Takes one probability element per cycle and gives one result per element: the first
// stage registers the -ln(p) term from a leading-one search and a 256-entry ln(1+f)
// table, the second updates the argmax, the saturating loss and correct totals and
// holds the result. Sustained rate is one transaction per cycle; the input is held
// off only while the result register is full and not being read. The user must write
// num_classes through cfg_wr_en/cfg_wr_data only while no transaction is in flight;
// the block does not enforce it. Resets to 10; 0 acts as 1, values above 1024 as 1024.
module softmax_cross_entropy_accuracy_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  scea_pkg::ncls_t        cfg_wr_data,
  scea_in_if.sink                in_ch,
  scea_out_if.source             out_ch
);
  import scea_pkg::*;

  ncls_t       num_classes_r;
  ncls_t       num_classes_nxt;
  logic        advance;
  logic        s1_valid;
  scea_stage_t s1_data;

  // Class count register.
  assign num_classes_nxt = cfg_wr_en ? cfg_wr_data : num_classes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_classes_r <= NCLS_RESET;
    end else begin
      num_classes_r <= num_classes_nxt;
    end
  end

  // Log-term stage.
  scea_lnterm u_lnterm (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_prob        (in_ch.prob),
    .in_label       (in_ch.label),
    .in_batch_start (in_ch.batch_start),
    .advance        (advance),
    .s1_valid       (s1_valid),
    .s1_data        (s1_data)
  );

  // Accumulate stage and result register.
  scea_accum u_accum (
    .clk                 (clk),
    .rst_n               (rst_n),
    .num_classes         (num_classes_r),
    .s1_valid            (s1_valid),
    .s1_data             (s1_data),
    .advance             (advance),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_grad            (out_ch.grad),
    .out_sample_done     (out_ch.sample_done),
    .out_predicted_class (out_ch.predicted_class),
    .out_sample_correct  (out_ch.sample_correct),
    .out_loss_total      (out_ch.loss_total),
    .out_correct_total   (out_ch.correct_total)
  );

endmodule

// ===== test/softmax_cross_entropy_accuracy_core_tb.sv =====
// Self-checking testbench for the streaming cross-entropy loss and argmax accuracy core.
module softmax_cross_entropy_accuracy_core_tb;
  import scea_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned UNITY_FIX    = 65536;
  localparam int unsigned LN2_FIX      = 45426;
  localparam int unsigned TERM_CEILING = 1207218;
  localparam int unsigned COUNT_RESET  = 10;
  localparam int unsigned PHASE_ITEMS  = 60;

  // One element as presented on the input channel.
  typedef struct {
    prob_t prob;
    cls_t  label;
    logic  batch_start;
  } elem_t;

  // One result as expected on the output channel.
  typedef struct {
    grad_t grad;
    logic  sample_done;
    cls_t  predicted_class;
    logic  sample_correct;
    loss_t loss_total;
    cnt_t  correct_total;
  } verdict_t;

  logic  clk;
  logic  rst_n;
  logic  cfg_wr_en;
  ncls_t cfg_wr_data;

  scea_in_if  in_ch ();
  scea_out_if out_ch ();

  softmax_cross_entropy_accuracy_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  elem_t    pending_elems [$];
  verdict_t expected_verdicts [$];

  // Predictor state: mirrors the core's sample position, argmax and totals.
  int unsigned count_cfg;
  int unsigned elem_pos;
  cls_t        held_class;
  int unsigned peak_prob;
  cls_t        peak_index;
  loss_t       loss_acc;
  cnt_t        hits_acc;
  logic [15:0] ln_frac_rom [LOG_TABLE_DEPTH];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned results_seen;
  int unsigned send_gap;
  int unsigned recv_gap;
  bit          idling_on;
  bit          in_taken;
  elem_t       drive_elem;
  elem_t       seen_elem;
  verdict_t    want;

  always #1 clk = ~clk;

  // ln(1 + i/depth) in unsigned Q0.16, found bit by bit through repeated squaring.
  function automatic logic [15:0] ln_one_plus(int unsigned i);
    logic [63:0] acc;
    logic [63:0] bits;
    acc  = (64'd1 << 30) + ((64'(i) << 30) / 64'(LOG_TABLE_DEPTH));
    bits = 64'd0;
    for (int b = 0; b < 24; b++) begin
      acc  = (acc * acc) >> 30;
      bits = bits << 1;
      if (acc >= (64'd2 << 30)) begin
        acc     = acc >> 1;
        bits[0] = 1'b1;
      end
    end
    return 16'((bits * 64'd2977044472 + (64'd1 << 39)) >> 40);
  endfunction

  // -ln(p) in Q16.16 from the leading-one position and the mantissa table, clamped.
  function automatic int unsigned loss_term(int unsigned p);
    int unsigned lead;
    int unsigned slot;
    int unsigned term;
    if (p == 0) return TERM_CEILING;
    lead = 0;
    for (int k = 0; k <= 16; k++) begin
      if (p[k]) lead = k;
    end
    slot = ((p - (32'd1 << lead)) * LOG_TABLE_DEPTH) >> lead;
    term = (16 - lead) * LN2_FIX;
    term = (term >= ln_frac_rom[slot]) ? term - ln_frac_rom[slot] : 0;
    return (term > TERM_CEILING) ? TERM_CEILING : term;
  endfunction

  // Advances the predictor by one accepted element and returns its expected result.
  function automatic verdict_t predict_element(elem_t e);
    verdict_t    v;
    int unsigned n;
    int unsigned p;
    int unsigned term;
    int          target;
    logic        on_label;
    logic        last;
    logic        hit;
    n = count_cfg;
    if (n == 0) n = 1;
    if (n > MAX_CLASSES) n = MAX_CLASSES;
    p = e.prob;
    if (p > UNITY_FIX) p = UNITY_FIX;
    if (e.batch_start) begin
      loss_acc = '0;
      hits_acc = '0;
    end
    if (elem_pos == 0) begin
      held_class = e.label;
      peak_prob  = 0;
      peak_index = '0;
    end
    on_label = (elem_pos == held_class);
    if (on_label) begin
      term     = loss_term(p);
      loss_acc = (loss_acc > 32'hFFFF_FFFF - term) ? 32'hFFFF_FFFF : loss_acc + term;
    end
    if (p > peak_prob) begin
      peak_prob  = p;
      peak_index = cls_t'(elem_pos);
    end
    last = (elem_pos + 1 >= n);
    hit  = 1'b0;
    if (last) begin
      hit = (peak_index == held_class);
      if (hit && hits_acc != 16'hFFFF) hits_acc = hits_acc + 1'b1;
    end
    target            = on_label ? int'(UNITY_FIX) : 0;
    v.grad            = grad_t'(target - int'(p));
    v.sample_done     = last;
    v.predicted_class = peak_index;
    v.sample_correct  = hit;
    v.loss_total      = loss_acc;
    v.correct_total   = hits_acc;
    elem_pos          = last ? 0 : elem_pos + 1;
    return v;
  endfunction

  // Prints one line per mismatch and counts every one.
  task automatic report_error(string what, longint got, longint exp_val);
    $display("mismatch at result %0d: %s got %0d, wanted %0d",
             results_seen, what, got, exp_val);
    error_count++;
  endtask

  task automatic push_elem(int unsigned p, int unsigned lbl, logic bs);
    elem_t e;
    e.prob        = prob_t'(p);
    e.label       = cls_t'(lbl);
    e.batch_start = bs;
    pending_elems.push_back(e);
  endtask

  // One sample of random content: peaked at the label, noise, ties and zeros, or flat.
  task automatic push_sample(int unsigned width_n);
    int unsigned lbl;
    int unsigned style;
    int unsigned pr;
    lbl   = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, width_n - 1);
    style = $urandom_range(0, 3);
    for (int unsigned i = 0; i < width_n; i++) begin
      case (style)
        0: pr = (i == lbl) ? $urandom_range(30000, 65536) : $urandom_range(0, 30000);
        1: pr = $urandom_range(0, 131071);
        2: begin
          case ($urandom_range(0, 3))
            0:       pr = 0;
            1:       pr = 1;
            2:       pr = 32768;
            default: pr = UNITY_FIX;
          endcase
        end
        default: pr = $urandom_range(0, 65536);
      endcase
      push_elem(pr, lbl, $urandom_range(0, 39) == 0);
    end
  endtask

  // Holds until every element is sent and every result has come back, then drains.
  task automatic settle();
    while (pending_elems.size() != 0 || in_ch.valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(int unsigned n);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ncls_t'(n);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Predictor and scoreboard: sampled at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("softmax_cross_entropy_accuracy_core_tb: errors");
      $finish;
    end else if (!rst_n) begin
      count_cfg  = COUNT_RESET;
      elem_pos   = 0;
      held_class = '0;
      peak_prob  = 0;
      peak_index = '0;
      loss_acc   = '0;
      hits_acc   = '0;
      in_taken   = 1'b0;
    end else begin
      if (cfg_wr_en) count_cfg = cfg_wr_data;
      // Check a result transaction against the oldest expectation.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_error("unexpected result, loss_total", out_ch.loss_total, 0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.grad !== want.grad)
            report_error("grad", longint'(out_ch.grad), longint'(want.grad));
          if (out_ch.sample_done !== want.sample_done)
            report_error("sample_done", out_ch.sample_done, want.sample_done);
          if (out_ch.predicted_class !== want.predicted_class)
            report_error("predicted_class", out_ch.predicted_class, want.predicted_class);
          if (out_ch.sample_correct !== want.sample_correct)
            report_error("sample_correct", out_ch.sample_correct, want.sample_correct);
          if (out_ch.loss_total !== want.loss_total)
            report_error("loss_total", out_ch.loss_total, want.loss_total);
          if (out_ch.correct_total !== want.correct_total)
            report_error("correct_total", out_ch.correct_total, want.correct_total);
        end
        results_seen++;
      end
      // Predict the result of an accepted input transaction.
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) begin
        seen_elem.prob        = in_ch.prob;
        seen_elem.label       = in_ch.label;
        seen_elem.batch_start = in_ch.batch_start;
        expected_verdicts.push_back(predict_element(seen_elem));
      end
    end
  end

  // Driver and result-side ready: changed at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      // Offer the next element once the previous transaction has gone.
      if (!in_ch.valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_elems.size() != 0 && idling_on && $urandom_range(0, 7) == 0) begin
          send_gap    = $urandom_range(0, 5);
          in_ch.valid <= 1'b0;
        end else if (pending_elems.size() != 0) begin
          drive_elem         = pending_elems.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.prob        <= drive_elem.prob;
          in_ch.label       <= drive_elem.label;
          in_ch.batch_start <= drive_elem.batch_start;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      // Stall the result channel in short bursts.
      if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        recv_gap     = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) ln_frac_rom[i] = ln_one_plus(i);
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.prob        = '0;
    in_ch.label       = '0;
    in_ch.batch_start = 1'b0;
    out_ch.ready      = 1'b0;
    idling_on         = 1'b1;
    cycle_count       = 0;
    error_count       = 0;
    results_seen      = 0;
    send_gap          = 0;
    recv_gap          = 0;
    in_taken          = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset class count: extremes of probability, saturation above one and a tie.
    push_elem(0, 3, 1'b1);
    push_elem(1, 3, 1'b0);
    push_elem(65535, 3, 1'b0);
    push_elem(UNITY_FIX, 3, 1'b0);
    push_elem(131071, 3, 1'b0);
    push_elem(100, 3, 1'b0);
    push_elem(UNITY_FIX, 3, 1'b0);
    push_elem(0, 3, 1'b0);
    push_elem(7, 3, 1'b0);
    push_elem(2, 3, 1'b0);
    // An all-zero sample predicts class zero and takes the clamped loss.
    for (int i = 0; i < 10; i++) push_elem(0, 0, 1'b0);
    settle();

    // Single-class samples, with a label beyond the class count.
    write_count(1);
    push_elem(UNITY_FIX, 1023, 1'b0);
    push_elem(0, 0, 1'b1);
    push_elem(32768, 0, 1'b0);
    settle();

    // A zero class count behaves as one.
    write_count(0);
    push_elem(12345, 0, 1'b0);
    push_elem(131071, 5, 1'b1);
    settle();

    // A count above the maximum, then shrunk mid-sample so the next element ends it.
    write_count(2047);
    for (int i = 0; i < 5; i++) push_elem($urandom_range(0, 65536), 700, i == 0);
    settle();
    write_count(3);
    push_sample(3);
    push_sample(3);
    settle();

    // Random phases over a range of class counts.
    for (int ph = 0; ph < 12; ph++) begin
      int unsigned n;
      int unsigned n_eff;
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = 1;
        default: n = $urandom_range(2, 16);
      endcase
      n_eff = (n == 0) ? 1 : n;
      if (ph == 11) idling_on = 1'b0;
      write_count(n);
      for (int s = 0; s < (PHASE_ITEMS + n_eff - 1) / n_eff; s++) push_sample(n_eff);
      settle();
    end

    if (error_count == 0) begin
      $display("softmax_cross_entropy_accuracy_core_tb: clean");
    end else begin
      $display("softmax_cross_entropy_accuracy_core_tb: errors");
    end
    $finish;
  end

endmodule
